/* rtl/swa_pkg.sv */
// Package for the session worker allocator: shared constants, codes, types
// and the worker count clamp. Used by swa_if, swa_cfg, swa_ctrl and the top level.
// Depends on nothing.
`default_nettype none

package swa_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int unsigned DEF_MAX_WORKERS  = 16;
  localparam int unsigned DEF_NUM_SESSIONS = 64;
  localparam int unsigned DEF_WAIT_DEPTH   = 64;

  // Fixed field widths of the channels.
  localparam int unsigned MODE_W       = 1;
  localparam int unsigned SESSION_W    = 7;
  localparam int unsigned ITEM_W       = 16;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned WORKER_OUT_W = 4;

  // Configuration register and port.
  localparam int unsigned WIU_W         = 5;
  localparam int unsigned RESET_WORKERS = 16;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam logic        REG_WORKERS_IN_USE = 1'b0;

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_WORK   = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FINISH = 1'b1;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    EV_BOUND    = 3'd0,
    EV_NEWBIND  = 3'd1,
    EV_QUEUED   = 3'd2,
    EV_DROPPED  = 3'd3,
    EV_RELEASED = 3'd4
  } event_kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } swa_state_t;

  // Rebuild request from the register block to the sequencer.
  typedef struct packed {
    logic             load;
    logic [WIU_W-1:0] workers;
  } swa_cfg_t;

  // A worker count of zero becomes one, and counts above the pool size
  // are limited to the pool size.
  function automatic logic [WIU_W-1:0] clamp_workers(input logic [WIU_W-1:0] v,
                                                     input int unsigned maxw);
    logic [WIU_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = WIU_W'(1);
    end else if (32'(v) > maxw) begin
      r = WIU_W'(maxw);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/swa_if.sv */
// Channel interfaces of the session worker allocator: request channel and
// event channel, each with valid/ready and its payload.
// Depends on swa_pkg for the field widths.
`default_nettype none

interface swa_req_if;
  logic                          valid;
  logic                          ready;
  logic [swa_pkg::MODE_W-1:0]    mode;
  logic [swa_pkg::SESSION_W-1:0] session_id;
  logic [swa_pkg::ITEM_W-1:0]    item_token;

  modport source (output valid, mode, session_id, item_token, input ready);
  modport sink   (input valid, mode, session_id, item_token, output ready);
endinterface

interface swa_evt_if;
  logic                             valid;
  logic                             ready;
  logic [swa_pkg::KIND_W-1:0]       event_kind;
  logic [swa_pkg::WORKER_OUT_W-1:0] worker_id;
  logic [swa_pkg::SESSION_W-1:0]    out_session;
  logic [swa_pkg::ITEM_W-1:0]       out_item;
  logic                             last;

  modport source (output valid, event_kind, worker_id, out_session, out_item, last,
                  input ready);
  modport sink   (input valid, event_kind, worker_id, out_session, out_item, last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/swa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the binding table, the free worker ring and the wait ring.
// Depends on nothing.
`default_nettype none

module swa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                   clk,
  input  wire                                   we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                      wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/swa_cfg.sv */
// APB register block of the session worker allocator: holds workers_in_use
// and signals a pool rebuild on every write to it.
// Depends on swa_pkg.
`default_nettype none

module swa_cfg #(
  parameter int unsigned MAX_WORKERS = swa_pkg::DEF_MAX_WORKERS
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [swa_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire  [swa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [swa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output swa_pkg::swa_cfg_t                cfg
);
  import swa_pkg::*;

  logic             wr_hit;
  logic [WIU_W-1:0] workers;
  logic [WIU_W-1:0] workers_next;

  // Register 0 sits at byte address 0; the upper address bit selects it.
  assign pready       = 1'b1;
  assign wr_hit       = psel && penable && pwrite && (paddr[2] == REG_WORKERS_IN_USE);
  assign workers_next = clamp_workers(pwdata[WIU_W-1:0], MAX_WORKERS);

  assign cfg.load    = wr_hit;
  assign cfg.workers = workers_next;

  // Stored value, after clamping.
  always_ff @(posedge clk) begin
    if (rst) begin
      workers <= clamp_workers(WIU_W'(RESET_WORKERS), MAX_WORKERS);
    end else if (wr_hit) begin
      workers <= workers_next;
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WORKERS_IN_USE) begin
      prdata = APB_DATA_W'(workers);
    end
  end

endmodule

`default_nettype wire

/* rtl/swa_ctrl.sv */
// Sequencer of the session worker allocator: reads the binding table, free
// ring and wait ring, decides the event, writes the memories back and emits
// results through an output register. Depends on swa_pkg, swa_if, swa_ram.
`default_nettype none

module swa_ctrl #(
  parameter int unsigned MAX_WORKERS  = swa_pkg::DEF_MAX_WORKERS,
  parameter int unsigned NUM_SESSIONS = swa_pkg::DEF_NUM_SESSIONS,
  parameter int unsigned WAIT_DEPTH   = swa_pkg::DEF_WAIT_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire swa_pkg::swa_cfg_t cfg,
  swa_req_if.sink                req,
  swa_evt_if.source              evt
);
  import swa_pkg::*;

  localparam int unsigned FW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned CW   = $clog2(MAX_WORKERS + 1);
  localparam int unsigned FSW  = CW + 1;
  localparam int unsigned SW   = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
  localparam int unsigned WW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned WCW  = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned WSW  = WCW + 1;
  localparam int unsigned QW   = SW + ITEM_W;

  swa_state_t state, state_next;

  // Item under work.
  logic [MODE_W-1:0] cur_mode;
  logic [SW-1:0]     cur_sidx;
  logic [ITEM_W-1:0] cur_item;
  logic              second;

  // Result waiting for the output register.
  event_kind_t          pend_kind;
  logic [FW-1:0]        pend_worker;
  logic [SESSION_W-1:0] pend_session;
  logic [ITEM_W-1:0]    pend_item;
  logic                 pend_last;
  logic                 more;

  // Pool and queue state.
  logic [NUM_SESSIONS-1:0] bvalid;
  logic [MAX_WORKERS-1:0]  fwritten;
  logic [FW-1:0]           free_head;
  logic [CW-1:0]           free_count;
  logic [WW-1:0]           wait_head;
  logic [WCW-1:0]          wait_count;

  // Memory ports.
  logic          bind_we;
  logic [SW-1:0] bind_raddr;
  logic [FW-1:0] bind_rdata;
  logic          free_we;
  logic [FW-1:0] free_rdata;
  logic          wait_we;
  logic [QW-1:0] wait_rdata;

  // Decode of the current lookup.
  logic          accept;
  logic          sess_ok;
  logic [SW-1:0] sidx_in;
  logic          bv;
  logic [FW-1:0] fw;
  logic          is_finish;
  logic          take_free;
  logic          do_queue;
  logic          do_push;
  logic          do_pop;
  logic [FSW-1:0] fsum;
  logic [FW-1:0]  ftail;
  logic [WSW-1:0] wsum;
  logic [WW-1:0]  wtail;
  logic [FW-1:0]  free_head_inc;
  logic [WW-1:0]  wait_head_inc;
  logic           emit_go;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign sess_ok   = (req.session_id != '0) && (32'(req.session_id) <= NUM_SESSIONS);
  assign sidx_in   = SW'(req.session_id - SESSION_W'(1));

  // Current binding and the worker at the head of the free ring; a slot
  // not written since the last rebuild holds its own index.
  assign bv = bvalid[cur_sidx];
  assign fw = fwritten[free_head] ? free_rdata : free_head;

  assign is_finish = (cur_mode == MODE_FINISH) && !second;
  assign take_free = (state == ST_LOOK) && !is_finish && !bv && (free_count != '0);
  assign do_queue  = (state == ST_LOOK) && !is_finish && !bv && (free_count == '0) &&
                     (32'(wait_count) < WAIT_DEPTH);
  assign do_push   = (state == ST_LOOK) && is_finish && bv &&
                     (32'(free_count) < MAX_WORKERS);
  assign do_pop    = (state == ST_LOOK) && is_finish && bv && (wait_count != '0);

  // Ring tail positions, wrapped with one compare and subtract.
  assign fsum  = FSW'(free_head) + FSW'(free_count);
  assign ftail = (32'(fsum) >= MAX_WORKERS) ? FW'(fsum - FSW'(MAX_WORKERS)) : FW'(fsum);
  assign wsum  = WSW'(wait_head) + WSW'(wait_count);
  assign wtail = (32'(wsum) >= WAIT_DEPTH) ? WW'(wsum - WSW'(WAIT_DEPTH)) : WW'(wsum);

  assign free_head_inc = (32'(free_head) == MAX_WORKERS - 1) ? '0 : FW'(free_head + FW'(1));
  assign wait_head_inc = (32'(wait_head) == WAIT_DEPTH - 1) ? '0 : WW'(wait_head + WW'(1));

  assign emit_go = (state == ST_EMIT) && (!evt.valid || evt.ready);

  // Binding table: worker per session; the valid bits live in bvalid.
  assign bind_we    = take_free;
  assign bind_raddr = (state == ST_IDLE) ? sidx_in : cur_sidx;

  swa_ram #(.WIDTH(FW), .DEPTH(NUM_SESSIONS)) u_bind_ram (
    .clk   (clk),
    .we    (bind_we),
    .waddr (cur_sidx),
    .wdata (fw),
    .raddr (bind_raddr),
    .rdata (bind_rdata)
  );

  // Free worker ring.
  assign free_we = do_push;

  swa_ram #(.WIDTH(FW), .DEPTH(MAX_WORKERS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (ftail),
    .wdata (bind_rdata),
    .raddr (free_head),
    .rdata (free_rdata)
  );

  // Wait ring: session index and item per entry.
  assign wait_we = do_queue;

  swa_ram #(.WIDTH(QW), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wtail),
    .wdata ({cur_sidx, cur_item}),
    .raddr (wait_head),
    .rdata (wait_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && sess_ok) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (is_finish && !bv) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = more ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Item registers and the pending result.
  always_ff @(posedge clk) begin
    if (accept && sess_ok) begin
      cur_mode <= req.mode;
      cur_sidx <= sidx_in;
      cur_item <= req.item_token;
      second   <= 1'b0;
    end
    if (emit_go && more) begin
      second <= 1'b1;
    end
    if (state == ST_LOOK) begin
      pend_session <= SESSION_W'(SESSION_W'(cur_sidx) + SESSION_W'(1));
      if (is_finish) begin
        pend_kind   <= EV_RELEASED;
        pend_worker <= bind_rdata;
        pend_item   <= '0;
        pend_last   <= !do_pop;
        more        <= do_pop;
        // The popped request becomes the item under work.
        if (do_pop) begin
          cur_sidx <= wait_rdata[QW-1:ITEM_W];
          cur_item <= wait_rdata[ITEM_W-1:0];
        end
      end else begin
        pend_item <= cur_item;
        pend_last <= 1'b1;
        more      <= 1'b0;
        if (bv) begin
          pend_kind   <= EV_BOUND;
          pend_worker <= bind_rdata;
        end else if (take_free) begin
          pend_kind   <= EV_NEWBIND;
          pend_worker <= fw;
        end else if (do_queue) begin
          pend_kind   <= EV_QUEUED;
          pend_worker <= '0;
        end else begin
          pend_kind   <= EV_DROPPED;
          pend_worker <= '0;
        end
      end
    end
  end

  // Pool bookkeeping; a rebuild empties everything and refills the pool.
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid     <= '0;
      fwritten   <= '0;
      free_head  <= '0;
      free_count <= CW'(clamp_workers(WIU_W'(RESET_WORKERS), MAX_WORKERS));
      wait_head  <= '0;
      wait_count <= '0;
    end else if (cfg.load) begin
      bvalid     <= '0;
      fwritten   <= '0;
      free_head  <= '0;
      free_count <= CW'(cfg.workers);
      wait_head  <= '0;
      wait_count <= '0;
    end else begin
      if (take_free) begin
        bvalid[cur_sidx] <= 1'b1;
        free_head        <= free_head_inc;
        free_count       <= CW'(free_count - CW'(1));
      end
      if (do_queue) begin
        wait_count <= WCW'(wait_count + WCW'(1));
      end
      if ((state == ST_LOOK) && is_finish && bv) begin
        bvalid[cur_sidx] <= 1'b0;
      end
      if (do_push) begin
        fwritten[ftail] <= 1'b1;
        free_count      <= CW'(free_count + CW'(1));
      end
      if (do_pop) begin
        wait_head  <= wait_head_inc;
        wait_count <= WCW'(wait_count - WCW'(1));
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (emit_go) begin
      evt.valid <= 1'b1;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      evt.event_kind  <= pend_kind;
      evt.worker_id   <= WORKER_OUT_W'(pend_worker);
      evt.out_session <= pend_session;
      evt.out_item    <= pend_item;
      evt.last        <= pend_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/session_worker_allocator_top.sv */
// Session worker allocator, top level: APB register block and sequencer.
// Requests enter on req, events leave on evt; both are valid/ready channels
// and a transfer happens at a rising edge with valid and ready both high.
// A work request gives one event; a finish of a bound session gives a
// release event and, when a request waits, a second event for it; last marks
// the final event of an input. Finishes of unbound sessions and sessions out
// of range give no event.
// The request transfer starts the binding, free ring and wait ring memory reads;
// LOOK decides and writes back, and EMIT moves the event into the output
// register. A request is taken only in IDLE, after the last one is through.
// A finish that pops a waiting request passes LOOK and EMIT again, since the
// popped request rereads the binding table and free ring after the release is written.
// When evt is stalled the pending event holds in the sequencer and no new
// request is taken until it has moved into the output register.
// Reset (rst, synchronous) clears all bindings, empties the wait queue and
// fills the free pool with workers 0 to min(15, MAX_WORKERS-1) at once; there
// is no clearing pass. Writing workers_in_use at address 0 does the same with the new count.
// Depends on swa_pkg, swa_if, swa_ram, swa_cfg and swa_ctrl.
`default_nettype none

module session_worker_allocator_top #(
  parameter int unsigned MAX_WORKERS  = swa_pkg::DEF_MAX_WORKERS,
  parameter int unsigned NUM_SESSIONS = swa_pkg::DEF_NUM_SESSIONS,
  parameter int unsigned WAIT_DEPTH   = swa_pkg::DEF_WAIT_DEPTH
) (
  input  wire                             clk,
  input  wire                             rst,
  swa_req_if.sink                         req,
  swa_evt_if.source                       evt,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [swa_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire  [swa_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [swa_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import swa_pkg::*;

  swa_cfg_t cfg;

  // Configuration register.
  swa_cfg #(.MAX_WORKERS(MAX_WORKERS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Allocation sequencer with its memories.
  swa_ctrl #(
    .MAX_WORKERS  (MAX_WORKERS),
    .NUM_SESSIONS (NUM_SESSIONS),
    .WAIT_DEPTH   (WAIT_DEPTH)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .evt (evt)
  );

endmodule

`default_nettype wire
